// ===== rtl/core/bfoc_pkg.sv =====
package bfoc_pkg;

  // Grid and list sizes
  localparam int GRID_SIDE    = 64;
  localparam int COORD_W      = $clog2(GRID_SIDE);
  localparam int CELL_W       = 2 * COORD_W;
  localparam int MAP_DEPTH    = GRID_SIDE * GRID_SIDE;
  localparam int OPEN_DEPTH   = 256;
  localparam int OPEN_CNT_W   = $clog2(OPEN_DEPTH + 1);
  localparam int CLOSED_DEPTH = 256;
  localparam int CLOSED_PTR_W = $clog2(CLOSED_DEPTH);
  localparam int CLOSED_CNT_W = $clog2(CLOSED_DEPTH + 1);

  // Unsigned Q1.16 value and key
  localparam int FRAC_W  = 16;
  localparam int VALUE_W = FRAC_W + 1;
  localparam int KEY_W   = VALUE_W;
  localparam logic [VALUE_W-1:0] ONE_Q16 = VALUE_W'(1) << FRAC_W;

  localparam int OP_W   = 2;
  localparam int STAT_W = 2;

  typedef enum logic [OP_W-1:0] {
    OP_INS_OPEN   = 2'd0,
    OP_INS_CLOSED = 2'd1,
    OP_POP_OPEN   = 2'd2,
    OP_POP_CLOSED = 2'd3
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_DONE    = 2'd0,
    STAT_PRESENT = 2'd1,
    STAT_EMPTY   = 2'd2,
    STAT_FULL    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC
  } state_t;

  // Membership map entry: {on closed list, on open list}
  typedef logic [1:0] map_ent_t;
  localparam map_ent_t MAP_NONE      = 2'b00;
  localparam map_ent_t MAP_ON_OPEN   = 2'b01;
  localparam map_ent_t MAP_ON_CLOSED = 2'b10;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [KEY_W-1:0]   key;
  } open_ent_t;

  typedef struct packed {
    logic ins;
    logic pop;
  } chain_cmd_t;

  typedef struct packed {
    logic              en;
    logic [CELL_W-1:0] addr;
    map_ent_t          data;
  } map_wr_t;

  // Clamp to one, then key = one minus value
  function automatic logic [KEY_W-1:0] key_of(input logic [VALUE_W-1:0] v);
    logic [KEY_W-1:0] k;
    if (v > ONE_Q16) begin
      k = '0;
    end else begin
      k = ONE_Q16 - v;
    end
    return k;
  endfunction

endpackage

// ===== rtl/core/bfoc_if.sv =====
interface bfoc_in_if;
  logic                           valid;
  logic                           ready;
  logic [bfoc_pkg::OP_W-1:0]      operation;
  logic [bfoc_pkg::COORD_W-1:0]   node_x;
  logic [bfoc_pkg::COORD_W-1:0]   node_y;
  logic [bfoc_pkg::VALUE_W-1:0]   node_value;

  modport source (output valid, operation, node_x, node_y, node_value, input ready);
  modport sink   (input valid, operation, node_x, node_y, node_value, output ready);
endinterface

interface bfoc_out_if;
  logic                           valid;
  logic                           ready;
  logic [bfoc_pkg::COORD_W-1:0]   out_x;
  logic [bfoc_pkg::COORD_W-1:0]   out_y;
  logic [bfoc_pkg::STAT_W-1:0]    status;

  modport source (output valid, out_x, out_y, status, input ready);
  modport sink   (input valid, out_x, out_y, status, output ready);
endinterface

// ===== rtl/core/bfoc_open_cell.sv =====
module bfoc_open_cell (
  input  logic                   clk,
  input  logic                   rst_n,
  input  bfoc_pkg::chain_cmd_t   cmd,
  input  bfoc_pkg::open_ent_t    new_ent,
  input  logic                   prev_vld,
  input  bfoc_pkg::open_ent_t    prev_ent,
  input  logic                   prev_place,
  input  logic                   next_vld,
  input  bfoc_pkg::open_ent_t    next_ent,
  output logic                   vld,
  output bfoc_pkg::open_ent_t    ent,
  output logic                   place
);

  logic                vld_r, vld_nxt;
  bfoc_pkg::open_ent_t ent_r, ent_nxt;

  // Strictly greater: equal keys stay ahead of the new entry
  assign place = !vld_r || (ent_r.key > new_ent.key);

  always_comb begin
    vld_nxt = vld_r;
    ent_nxt = ent_r;
    if (cmd.pop) begin
      vld_nxt = next_vld;
      ent_nxt = next_ent;
    end else if (cmd.ins && place) begin
      if (prev_place) begin
        vld_nxt = prev_vld;
        ent_nxt = prev_ent;
      end else begin
        vld_nxt = 1'b1;
        ent_nxt = new_ent;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

  assign vld = vld_r;
  assign ent = ent_r;

endmodule

// ===== rtl/core/bfoc_open_chain.sv =====
module bfoc_open_chain (
  input  logic                              clk,
  input  logic                              rst_n,
  input  bfoc_pkg::chain_cmd_t              cmd,
  input  bfoc_pkg::open_ent_t               new_ent,
  output logic                              head_vld,
  output bfoc_pkg::open_ent_t               head_ent,
  output logic [bfoc_pkg::OPEN_CNT_W-1:0]   count
);

  localparam int N = bfoc_pkg::OPEN_DEPTH;

  logic                vld   [N];
  bfoc_pkg::open_ent_t ent   [N];
  logic                place [N];

  logic [bfoc_pkg::OPEN_CNT_W-1:0] cnt_r, cnt_nxt;

  for (genvar i = 0; i < N; i++) begin : g_cell
    logic                p_vld, p_place, n_vld;
    bfoc_pkg::open_ent_t p_ent, n_ent;

    if (i == 0) begin : g_first
      assign p_vld   = 1'b0;
      assign p_place = 1'b0;
      assign p_ent   = '0;
    end else begin : g_inner
      assign p_vld   = vld[i-1];
      assign p_place = place[i-1];
      assign p_ent   = ent[i-1];
    end

    if (i == N - 1) begin : g_last
      assign n_vld = 1'b0;
      assign n_ent = '0;
    end else begin : g_body
      assign n_vld = vld[i+1];
      assign n_ent = ent[i+1];
    end

    bfoc_open_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cmd        (cmd),
      .new_ent    (new_ent),
      .prev_vld   (p_vld),
      .prev_ent   (p_ent),
      .prev_place (p_place),
      .next_vld   (n_vld),
      .next_ent   (n_ent),
      .vld        (vld[i]),
      .ent        (ent[i]),
      .place      (place[i])
    );
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end else if (cmd.ins) begin
      cnt_nxt = cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  assign head_vld = vld[0];
  assign head_ent = ent[0];
  assign count    = cnt_r;

endmodule

// ===== rtl/core/bfoc_closed_fifo.sv =====
module bfoc_closed_fifo (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                push,
  input  logic [bfoc_pkg::CELL_W-1:0]         push_data,
  input  logic                                pop,
  output logic [bfoc_pkg::CELL_W-1:0]         head_data,
  output logic [bfoc_pkg::CLOSED_CNT_W-1:0]   count
);

  localparam int PW = bfoc_pkg::CLOSED_PTR_W;
  localparam logic [PW-1:0] LAST = PW'(bfoc_pkg::CLOSED_DEPTH - 1);

  logic [bfoc_pkg::CELL_W-1:0] mem [bfoc_pkg::CLOSED_DEPTH];
  logic [bfoc_pkg::CELL_W-1:0] rd_r;

  logic [PW-1:0]                        head_r, head_nxt, tail_r, tail_nxt;
  logic [bfoc_pkg::CLOSED_CNT_W-1:0]    cnt_r, cnt_nxt;

  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    cnt_nxt  = cnt_r;
    if (push) begin
      tail_nxt = (tail_r == LAST) ? '0 : tail_r + 1'b1;
      cnt_nxt  = cnt_r + 1'b1;
    end else if (pop) begin
      head_nxt = (head_r == LAST) ? '0 : head_r + 1'b1;
      cnt_nxt  = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      cnt_r  <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[tail_r] <= push_data;
    end
    rd_r <= mem[head_r];
  end

  assign head_data = rd_r;
  assign count     = cnt_r;

endmodule

// ===== rtl/core/bfoc_member_map.sv =====
module bfoc_member_map (
  input  logic                          clk,
  input  logic                          rst_n,
  input  bfoc_pkg::map_wr_t             wr,
  input  logic [bfoc_pkg::CELL_W-1:0]   raddr,
  output bfoc_pkg::map_ent_t            rdata,
  output logic                          busy
);

  localparam logic [bfoc_pkg::CELL_W-1:0] LAST = bfoc_pkg::CELL_W'(bfoc_pkg::MAP_DEPTH - 1);

  bfoc_pkg::map_ent_t mem [bfoc_pkg::MAP_DEPTH];
  bfoc_pkg::map_ent_t rd_r;

  logic [bfoc_pkg::CELL_W-1:0] clr_r, clr_nxt;
  logic                        busy_r, busy_nxt;

  // Sweep every entry to zero after reset
  always_comb begin
    clr_nxt  = clr_r;
    busy_nxt = busy_r;
    if (busy_r) begin
      clr_nxt = clr_r + 1'b1;
      if (clr_r == LAST) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r  <= '0;
      busy_r <= 1'b1;
    end else begin
      clr_r  <= clr_nxt;
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (busy_r) begin
      mem[clr_r] <= bfoc_pkg::MAP_NONE;
    end else if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_r <= mem[raddr];
  end

  assign rdata = rd_r;
  assign busy  = busy_r;

endmodule

// ===== rtl/core/best_first_open_closed_lists.sv =====
// Channel   Dir  Handshake      Payload
// in_chan   in   valid/ready    operation, node_x, node_y, node_value
// out_chan  out  valid/ready    out_x, out_y, status
//
// For each item the membership map (and the closed queue head) is read
// first; then the item is decided, the lists are updated and the result
// register is loaded. The map read is registered and the decision waits
// for it. After reset the map is swept to zero; in_chan.ready stays low
// until the sweep ends.
// A result waiting in the output register stalls the decide cycle only.
module best_first_open_closed_lists (
  input  logic          clk,
  input  logic          rst_n,
  bfoc_in_if.sink       in_chan,
  bfoc_out_if.source    out_chan
);

  localparam int CW = bfoc_pkg::COORD_W;

  // Control
  bfoc_pkg::state_t state_r, state_nxt;
  logic             in_acc;
  logic             out_free;
  logic             fire;

  // Captured item
  bfoc_pkg::op_t                 op_r;
  logic [CW-1:0]                 x_r, y_r;
  logic [bfoc_pkg::KEY_W-1:0]    key_r;

  // Result register
  logic                          out_valid_r, out_valid_nxt;
  logic [CW-1:0]                 out_x_r, out_y_r, res_x, res_y;
  bfoc_pkg::status_t             out_stat_r, res_stat;

  // Submodule hookups
  bfoc_pkg::chain_cmd_t                 chain_cmd;
  bfoc_pkg::open_ent_t                  new_ent, head_ent;
  logic                                 head_vld;
  logic [bfoc_pkg::OPEN_CNT_W-1:0]      open_cnt;

  logic                                 fifo_push, fifo_pop;
  logic [bfoc_pkg::CELL_W-1:0]          fifo_head;
  logic [bfoc_pkg::CLOSED_CNT_W-1:0]    closed_cnt;

  bfoc_pkg::map_wr_t                    map_wr;
  logic [bfoc_pkg::CELL_W-1:0]          map_raddr;
  bfoc_pkg::map_ent_t                   map_rd;
  logic                                 map_busy;
  logic                                 present;

  assign in_acc   = in_chan.valid && in_chan.ready;
  assign out_free = !out_valid_r || out_chan.ready;
  assign fire     = (state_r == bfoc_pkg::S_EXEC) && out_free;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bfoc_pkg::S_CLEAR: begin
        if (!map_busy) state_nxt = bfoc_pkg::S_IDLE;
      end
      bfoc_pkg::S_IDLE: begin
        if (in_chan.valid) state_nxt = bfoc_pkg::S_EXEC;
      end
      bfoc_pkg::S_EXEC: begin
        if (out_free) state_nxt = bfoc_pkg::S_IDLE;
      end
      default: state_nxt = bfoc_pkg::S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bfoc_pkg::S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Capture the item on transfer; key is computed here
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r  <= bfoc_pkg::op_t'(in_chan.operation);
      x_r   <= in_chan.node_x;
      y_r   <= in_chan.node_y;
      key_r <= bfoc_pkg::key_of(in_chan.node_value);
    end
  end

  // Map is read at the incoming node during the transfer cycle, then held
  assign map_raddr = (state_r == bfoc_pkg::S_IDLE) ? {in_chan.node_x, in_chan.node_y}
                                                   : {x_r, y_r};
  assign present   = (map_rd != bfoc_pkg::MAP_NONE);

  assign new_ent.x   = x_r;
  assign new_ent.y   = y_r;
  assign new_ent.key = key_r;

  // Outputs and list updates
  always_comb begin
    in_chan.ready = (state_r == bfoc_pkg::S_IDLE);
    chain_cmd     = '0;
    fifo_push     = 1'b0;
    fifo_pop      = 1'b0;
    map_wr        = '0;
    res_x         = '0;
    res_y         = '0;
    res_stat      = bfoc_pkg::STAT_DONE;
    case (op_r)
      bfoc_pkg::OP_INS_OPEN: begin
        if (present) begin
          res_stat = bfoc_pkg::STAT_PRESENT;
        end else if (open_cnt == bfoc_pkg::OPEN_CNT_W'(bfoc_pkg::OPEN_DEPTH)) begin
          res_stat = bfoc_pkg::STAT_FULL;
        end else begin
          chain_cmd.ins = fire;
          map_wr.en     = fire;
          map_wr.addr   = {x_r, y_r};
          map_wr.data   = bfoc_pkg::MAP_ON_OPEN;
        end
      end
      bfoc_pkg::OP_INS_CLOSED: begin
        if (present) begin
          res_stat = bfoc_pkg::STAT_PRESENT;
        end else if (closed_cnt == bfoc_pkg::CLOSED_CNT_W'(bfoc_pkg::CLOSED_DEPTH)) begin
          res_stat = bfoc_pkg::STAT_FULL;
        end else begin
          fifo_push   = fire;
          map_wr.en   = fire;
          map_wr.addr = {x_r, y_r};
          map_wr.data = bfoc_pkg::MAP_ON_CLOSED;
        end
      end
      bfoc_pkg::OP_POP_OPEN: begin
        if (open_cnt == '0) begin
          res_stat = bfoc_pkg::STAT_EMPTY;
        end else begin
          res_x         = head_ent.x;
          res_y         = head_ent.y;
          chain_cmd.pop = fire;
          map_wr.en     = fire;
          map_wr.addr   = {head_ent.x, head_ent.y};
          map_wr.data   = bfoc_pkg::MAP_NONE;
        end
      end
      bfoc_pkg::OP_POP_CLOSED: begin
        if (closed_cnt == '0) begin
          res_stat = bfoc_pkg::STAT_EMPTY;
        end else begin
          res_x       = fifo_head[bfoc_pkg::CELL_W-1:CW];
          res_y       = fifo_head[CW-1:0];
          fifo_pop    = fire;
          map_wr.en   = fire;
          map_wr.addr = fifo_head;
          map_wr.data = bfoc_pkg::MAP_NONE;
        end
      end
      default: res_stat = bfoc_pkg::STAT_DONE;
    endcase
  end

  // Result register: load on decide, drop once transferred
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_x_r    <= res_x;
      out_y_r    <= res_y;
      out_stat_r <= res_stat;
    end
  end

  assign out_chan.valid  = out_valid_r;
  assign out_chan.out_x  = out_x_r;
  assign out_chan.out_y  = out_y_r;
  assign out_chan.status = out_stat_r;

  bfoc_open_chain u_open (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (chain_cmd),
    .new_ent  (new_ent),
    .head_vld (head_vld),
    .head_ent (head_ent),
    .count    (open_cnt)
  );

  bfoc_closed_fifo u_closed (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (fifo_push),
    .push_data ({x_r, y_r}),
    .pop       (fifo_pop),
    .head_data (fifo_head),
    .count     (closed_cnt)
  );

  bfoc_member_map u_map (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (map_wr),
    .raddr (map_raddr),
    .rdata (map_rd),
    .busy  (map_busy)
  );

  // Open count must track the occupied cells of the chain
  a_head_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
    (open_cnt != '0) == head_vld)
    else $error("open chain head valid disagrees with open count");

  a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    map_busy |-> !in_chan.ready)
    else $error("input ready during map sweep");

  a_decide_loads_result: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_valid_r)
    else $error("decided item did not reach the result register");

  a_single_list_update: assert property (@(posedge clk) disable iff (!rst_n)
    $countones({chain_cmd.ins, chain_cmd.pop, fifo_push, fifo_pop}) <= 1)
    else $error("more than one list updated in a cycle");

endmodule
